// ===== rtl/ppsc_pkg.sv =====
package ppsc_pkg;

    // default sizing of the job table and time base
    localparam int DEF_NUM_JOBS  = 16;
    localparam int DEF_TIME_BITS = 16;
    localparam int DEF_PRIO_BITS = 8;

    // fixed field widths on the stream ports
    localparam int SLOT_W      = 4;
    localparam int TIME_W      = 16;
    localparam int PRIO_W      = 8;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    // request kind carried on the input tuser
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // input request payload, last field (slot) in the lowest bits
    typedef struct packed {
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] service;
        logic [TIME_W-1:0] arrival;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    localparam int IN_ITEM_W = $bits(t_in_item);

    // result payload, last field (running_slot) in the lowest bits
    typedef struct packed {
        logic              all_done;
        logic [TIME_W-1:0] weighted_turnaround;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] start_time;
        logic              finished;
        logic              idle;
        logic [SLOT_W-1:0] running_slot;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_step;
        logic load;
        logic rd_best;
        logic update;
        logic clk_adv;
        logic res_idle;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic found;
        logic finishing;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// Preemptive priority scheduler over a table of NUM_JOBS job slots. A load
// request (tuser = 0) writes one slot with arrival, service and priority and
// marks it valid; loads to a slot beyond the table are dropped. A tick request
// (tuser = 1) runs one time unit: the valid, unfinished, already-arrived job
// with the smallest priority number runs (lowest slot on ties), the clock
// advances and saturates at all ones, and a completing job reports start,
// finish, turnaround and truncated turnaround/service (all ones for zero
// service). Every request returns exactly one result. A load captures the
// request and writes its slot; a tick scans the table one memory entry per
// cycle, then reads and updates the picked job, or advances the clock when
// no job is ready; a completing tick then waits for the bit-serial divider.
// The next request is taken in the cycle after the result enters the
// output register, whether or not it has been taken yet.
module preemptive_priority_scheduler_core #(
    parameter int NUM_JOBS  = ppsc_pkg::DEF_NUM_JOBS,
    parameter int TIME_BITS = ppsc_pkg::DEF_TIME_BITS,
    parameter int PRIO_BITS = ppsc_pkg::DEF_PRIO_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot[3:0], arrival[19:4], service[35:20], priority_req[43:36]
    input  logic [ppsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // running_slot[3:0], idle[4], finished[5], start_time[21:6],
    // finish_time[37:22], turnaround[53:38], weighted_turnaround[69:54],
    // all_done[70]
    output logic [ppsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ppsc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    ppsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // job table, scan, divider and result registers
    ppsc_dpath #(
        .NUM_JOBS  (NUM_JOBS),
        .TIME_BITS (TIME_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/ppsc_div.sv =====
module ppsc_div #(
    parameter int W = ppsc_pkg::DEF_TIME_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    import ppsc_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;

    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;
    logic [W-1:0]     rem_nxt;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
        rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    end

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= rem_nxt;
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/ppsc_dpath.sv =====
module ppsc_dpath #(
    parameter int NUM_JOBS  = ppsc_pkg::DEF_NUM_JOBS,
    parameter int TIME_BITS = ppsc_pkg::DEF_TIME_BITS,
    parameter int PRIO_BITS = ppsc_pkg::DEF_PRIO_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ppsc_pkg::t_dp_cmd                  i_cmd,
    output ppsc_pkg::t_dp_sts                  o_sts,
    input  logic [ppsc_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [ppsc_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import ppsc_pkg::*;

    localparam int IDX_W = $clog2(NUM_JOBS);
    localparam int CNT_W = $clog2(NUM_JOBS + 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] service;
        logic [TIME_BITS-1:0] remaining;
        logic [PRIO_BITS-1:0] prio;
        logic [TIME_BITS-1:0] start;
    } t_job;

    // job table memory and its registered read port
    t_job                 r_mem [NUM_JOBS];
    t_job                 r_rd_data;

    t_in_item             r_in;
    logic [NUM_JOBS-1:0]  r_valid;
    logic [NUM_JOBS-1:0]  r_done;
    logic [NUM_JOBS-1:0]  r_started;
    logic [TIME_BITS-1:0] r_clock;

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best;
    logic [PRIO_BITS-1:0] r_best_prio;

    t_res                 r_stage;
    t_res                 r_out;
    logic                 r_out_valid;
    logic                 r_div_zero;

    t_res                 n_stage;
    t_res                 n_out;

    logic                 slot_ok;
    logic [IDX_W-1:0]     load_idx;
    logic                 scan_more;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    t_job                 mem_wdata;
    logic                 cand_ready;
    logic                 cand_better;
    logic [TIME_BITS-1:0] clk_nxt;
    logic [TIME_BITS-1:0] rem_nxt;
    logic                 finishing;
    logic [TIME_BITS-1:0] start_val;
    logic [TIME_BITS-1:0] turn;
    logic                 div_start;
    logic                 div_done;
    logic [TIME_BITS-1:0] div_quot;
    logic                 out_free;

    // load decode
    assign slot_ok   = (32'(r_in.slot) < NUM_JOBS);
    assign load_idx  = IDX_W'(r_in.slot);
    assign scan_more = (r_cnt < CNT_W'(NUM_JOBS));

    // saturating clock increment
    assign clk_nxt = (r_clock == '1) ? r_clock : r_clock + 1'b1;

    // run of the picked job, read data is the picked entry
    always_comb begin
        rem_nxt   = (r_rd_data.remaining == '0) ? '0 : r_rd_data.remaining - 1'b1;
        finishing = (rem_nxt == '0);
        start_val = r_started[r_best] ? r_rd_data.start : r_clock;
        turn      = clk_nxt - r_rd_data.arrival;
    end

    // memory port selection
    always_comb begin
        rd_en     = (i_cmd.scan_step && scan_more) || i_cmd.rd_best;
        rd_addr   = i_cmd.rd_best ? r_best : r_cnt[IDX_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_best;
        mem_wdata = '0;
        if (i_cmd.load) begin
            mem_we              = slot_ok;
            mem_waddr           = load_idx;
            mem_wdata.arrival   = TIME_BITS'(r_in.arrival);
            mem_wdata.service   = TIME_BITS'(r_in.service);
            mem_wdata.remaining = TIME_BITS'(r_in.service);
            mem_wdata.prio      = PRIO_BITS'(r_in.priority_req);
        end else if (i_cmd.update) begin
            mem_we              = 1'b1;
            mem_wdata.arrival   = r_rd_data.arrival;
            mem_wdata.service   = r_rd_data.service;
            mem_wdata.remaining = rem_nxt;
            mem_wdata.prio      = r_rd_data.prio;
            mem_wdata.start     = start_val;
        end
    end

    // job table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= t_in_item'(i_in_data[IN_ITEM_W-1:0]);
        end
    end

    // per-slot flags and the time base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_done    <= '0;
            r_started <= '0;
            r_clock   <= '0;
        end else begin
            if (i_cmd.load && slot_ok) begin
                r_valid[load_idx]   <= 1'b1;
                r_done[load_idx]    <= 1'b0;
                r_started[load_idx] <= 1'b0;
            end
            if (i_cmd.update) begin
                r_started[r_best] <= 1'b1;
                if (finishing) begin
                    r_done[r_best] <= 1'b1;
                end
            end
            if (i_cmd.update || i_cmd.clk_adv) begin
                r_clock <= clk_nxt;
            end
        end
    end

    // candidate test on the entry read in the previous cycle
    assign cand_ready  = r_valid[r_cmp_idx] && !r_done[r_cmp_idx] &&
                         (r_rd_data.arrival <= r_clock);
    assign cand_better = !r_found || (r_rd_data.prio < r_best_prio);

    // scan over the table, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step && scan_more;
            if (i_cmd.scan_init) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_step && scan_more) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_cmp_vld && cand_ready && cand_better) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && scan_more) begin
            r_cmp_idx <= r_cnt[IDX_W-1:0];
        end
        if (r_cmp_vld && cand_ready && cand_better) begin
            r_best      <= r_cmp_idx;
            r_best_prio <= r_rd_data.prio;
        end
    end

    // weighted turnaround
    assign div_start = i_cmd.update && finishing;

    ppsc_div #(
        .W (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (turn),
        .i_divisor  (r_rd_data.service),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // result staging
    always_comb begin
        n_stage = r_stage;
        if (i_cmd.res_idle) begin
            n_stage      = '0;
            n_stage.idle = 1'b1;
        end else if (i_cmd.update) begin
            n_stage              = '0;
            n_stage.running_slot = SLOT_W'(r_best);
            n_stage.finished     = finishing;
            if (finishing) begin
                n_stage.start_time  = TIME_W'(start_val);
                n_stage.finish_time = TIME_W'(clk_nxt);
                n_stage.turnaround  = TIME_W'(turn);
            end
        end else if (div_done) begin
            n_stage.weighted_turnaround = r_div_zero ? '1 : TIME_W'(div_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (i_cmd.update) begin
            r_div_zero <= (r_rd_data.service == '0);
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out          = r_stage;
        n_out.all_done = ~|(r_valid & ~r_done);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_TDATA_W'(r_out);

    // status back to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.scan_done = !scan_more && !r_cmp_vld;
        o_sts.found     = r_found;
        o_sts.finishing = finishing;
        o_sts.div_done  = div_done;
        o_sts.out_free  = out_free;
    end

`ifndef SYNTHESIS
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_pick_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_best |-> (r_found && r_valid[r_best] && !r_done[r_best]))
        else $error("picked slot is not a live job");

    a_res_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.idle && r_out.finished))
        else $error("idle result marked finished");

    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_done)
        else $error("divider finished without iterating");
`endif

endmodule

// ===== rtl/ppsc_ctrl.sv =====
module ppsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_ready,
    output ppsc_pkg::t_dp_cmd o_cmd,
    input  ppsc_pkg::t_dp_sts i_sts
);
    import ppsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_UPDATE,
        S_DIV,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (t_cmd'(i_in_kind) == CMD_LOAD) begin
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load     = 1'b1;
                o_cmd.res_idle = 1'b1;
                n_state        = S_RESULT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.found) begin
                    o_cmd.rd_best = 1'b1;
                    n_state       = S_UPDATE;
                end else begin
                    o_cmd.clk_adv  = 1'b1;
                    o_cmd.res_idle = 1'b1;
                    n_state        = S_RESULT;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.finishing ? S_DIV : S_RESULT;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== verif/ppsc_schedule_checker.sv =====
module ppsc_schedule_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    // slot[3:0], arrival[19:4], service[35:20], priority_req[43:36]
    input  logic [ppsc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd[0]
    input  logic                             i_s_axis_tuser,
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // running_slot[3:0], idle[4], finished[5], start_time[21:6],
    // finish_time[37:22], turnaround[53:38], weighted_turnaround[69:54],
    // all_done[70]
    input  logic [ppsc_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    output int                               o_fail_count,
    output int                               o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import ppsc_pkg::*;

    localparam int NUM_SLOTS = DEF_NUM_JOBS;

    // shadow copy of the job table and time base
    logic [TIME_W-1:0]    sched_clock;
    logic [NUM_SLOTS-1:0] slot_valid;
    logic [NUM_SLOTS-1:0] slot_done;
    logic [NUM_SLOTS-1:0] slot_started;
    logic [TIME_W-1:0]    slot_arrival   [NUM_SLOTS];
    logic [TIME_W-1:0]    slot_service   [NUM_SLOTS];
    logic [TIME_W-1:0]    slot_remaining [NUM_SLOTS];
    logic [PRIO_W-1:0]    slot_prio      [NUM_SLOTS];
    logic [TIME_W-1:0]    slot_start     [NUM_SLOTS];

    t_res results_due[$];
    int   fail_total = 0;

    assign o_fail_count = fail_total;

    // true when no valid job is still unfinished
    function automatic logic table_settled();
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i] && !slot_done[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // apply one request to the shadow table and return the result it causes
    function automatic t_res schedule_step(t_cmd kind, t_in_item req);
        t_res res;
        int   winner;
        res      = '0;
        res.idle = 1'b1;
        winner   = -1;
        if (kind == CMD_LOAD) begin
            slot_valid[req.slot]     = 1'b1;
            slot_done[req.slot]      = 1'b0;
            slot_started[req.slot]   = 1'b0;
            slot_arrival[req.slot]   = req.arrival;
            slot_service[req.slot]   = req.service;
            slot_remaining[req.slot] = req.service;
            slot_prio[req.slot]      = req.priority_req;
            slot_start[req.slot]     = '0;
        end else begin
            // smallest priority number among arrived jobs, lowest slot on ties
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_valid[i] && !slot_done[i] && slot_arrival[i] <= sched_clock &&
                    (winner < 0 || slot_prio[i] < slot_prio[winner]))
                    winner = i;
            if (winner >= 0) begin
                if (!slot_started[winner]) begin
                    slot_started[winner] = 1'b1;
                    slot_start[winner]   = sched_clock;
                end
                if (slot_remaining[winner] != '0)
                    slot_remaining[winner]--;
            end
            // time base stops at all ones
            if (sched_clock != '1)
                sched_clock++;
            if (winner >= 0) begin
                res.running_slot = SLOT_W'(winner);
                res.idle         = 1'b0;
                if (slot_remaining[winner] == '0) begin
                    slot_done[winner]   = 1'b1;
                    res.finished        = 1'b1;
                    res.start_time      = slot_start[winner];
                    res.finish_time     = sched_clock;
                    res.turnaround      = sched_clock - slot_arrival[winner];
                    res.weighted_turnaround = (slot_service[winner] == '0) ? '1 :
                        res.turnaround / slot_service[winner];
                end
            end
        end
        res.all_done = table_settled();
        return res;
    endfunction

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] seen);
        if (seen !== want) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, seen);
            fail_total++;
        end
    endfunction

    // compare results first, then book the new request
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            sched_clock  = '0;
            slot_valid   = '0;
            slot_done    = '0;
            slot_started = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_arrival[i]   = '0;
                slot_service[i]   = '0;
                slot_remaining[i] = '0;
                slot_prio[i]      = '0;
                slot_start[i]     = '0;
            end
            results_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_res'(i_m_axis_tdata[$bits(t_res)-1:0]);
                if (results_due.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, i_m_axis_tdata);
                    fail_total++;
                end else begin
                    want = results_due.pop_front();
                    check_field("running_slot", TIME_W'(want.running_slot),
                                TIME_W'(got.running_slot));
                    check_field("idle", TIME_W'(want.idle), TIME_W'(got.idle));
                    check_field("finished", TIME_W'(want.finished), TIME_W'(got.finished));
                    check_field("start_time", want.start_time, got.start_time);
                    check_field("finish_time", want.finish_time, got.finish_time);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("weighted_turnaround", want.weighted_turnaround,
                                got.weighted_turnaround);
                    check_field("all_done", TIME_W'(want.all_done), TIME_W'(got.all_done));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                results_due.push_back(schedule_step(t_cmd'(i_s_axis_tuser),
                                      t_in_item'(i_s_axis_tdata[IN_ITEM_W-1:0])));
        end
        o_pending <= results_due.size();
    end

endmodule

// ===== verif/preemptive_priority_scheduler_core_test.sv =====
module preemptive_priority_scheduler_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ppsc_pkg::*;

    localparam int RANDOM_REQUESTS = 1800;
    localparam int SETTLE_CYCLES   = DEF_NUM_JOBS + DEF_TIME_BITS + 16;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // slot[3:0], arrival[19:4], service[35:20], priority_req[43:36]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // cmd[0]
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // running_slot[3:0], idle[4], finished[5], start_time[21:6],
    // finish_time[37:22], turnaround[53:38], weighted_turnaround[69:54],
    // all_done[70]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int results_pending;
    int tick_count    = 0;
    bit steady_sender = 1'b0;

    preemptive_priority_scheduler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ppsc_schedule_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (mismatch_count),
        .o_pending       (results_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sender pause: mostly none or short, now and then long
    function automatic int sender_pause();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver backpressure with occasional long open stretches
    always begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(50, 300)) @(posedge i_clk);
        else
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        if ($urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b0;
            if ($urandom_range(0, 99) < 85)
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            else
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
        end
    end

    // present one request and hold it until taken
    task automatic send_request(input t_cmd kind, input t_in_item req);
        int pause;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_ITEM_W){1'b0}}, req};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (kind == CMD_TICK)
            tick_count++;
        pause = steady_sender ? 0 : sender_pause();
        if (pause > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    task automatic load_job(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] arrival,
                            input logic [TIME_W-1:0] service, input logic [PRIO_W-1:0] prio);
        t_in_item req;
        req.slot         = slot;
        req.arrival      = arrival;
        req.service      = service;
        req.priority_req = prio;
        send_request(CMD_LOAD, req);
    endtask

    // tick with random junk in the unused payload fields
    task automatic tick_once();
        send_request(CMD_TICK, t_in_item'(IN_ITEM_W'({$urandom(), $urandom()})));
    endtask

    // mostly near-term short jobs, some far arrivals, long or zero service
    task automatic load_random_job();
        int                kind_pick;
        int                base;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
        logic [PRIO_W-1:0] prio;
        kind_pick = $urandom_range(0, 99);
        base      = (tick_count > 10) ? tick_count - 10 : 0;
        arrival   = TIME_W'(base + $urandom_range(0, 15));
        service   = TIME_W'($urandom_range(1, 4));
        prio      = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3)) :
                    PRIO_W'($urandom_range(0, 255));
        if (kind_pick < 4)
            arrival = TIME_W'($urandom_range(0, 65535));
        else if (kind_pick < 7)
            service = TIME_W'($urandom_range(0, 65535));
        else if (kind_pick < 12)
            service = '0;
        load_job(SLOT_W'($urandom_range(0, 15)), arrival, service, prio);
    endtask

    // stop sending until every outstanding result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, ties, zero service, preemption, reload
        tick_once();
        load_job(4'd0, 16'd0, 16'd2, 8'd255);
        load_job(4'd15, 16'd0, 16'd0, 8'd0);
        load_job(4'd1, 16'd0, 16'd1, 8'd255);
        load_job(4'd3, 16'hFFFF, 16'hFFFF, 8'd0);
        tick_once();
        tick_once();
        tick_once();
        tick_once();
        load_job(4'd5, TIME_W'(tick_count + 2), 16'd3, 8'd10);
        tick_once();
        tick_once();
        tick_once();
        load_job(4'd6, TIME_W'(tick_count), 16'd2, 8'd5);
        tick_once();
        tick_once();
        tick_once();
        tick_once();
        load_job(4'd3, 16'd0, 16'd1, 8'd128);
        tick_once();
        drain_results();

        // random: well-formed job mix with periodic full drains
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0)
                steady_sender = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399)
                drain_results();
            if ($urandom_range(0, 99) < 25)
                load_random_job();
            else
                tick_once();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (results_pending != 0)
            $display("%0t %0d expected results never arrived", $time, results_pending);
        if (mismatch_count == 0 && results_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
